// File: sv/wildcard_byte_pattern_scanner_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wildcard byte pattern scanner
// Concurrent checks, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_CORE_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define WBPS_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WBPS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define WBPS_ASSERT_NOW(name, clk, rst, ante, cons, msg)
`define WBPS_ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

// File: sv/wbps_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner package
// Register indexes and fixed widths shared by the scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int ADDR_W        = 48;
  localparam int MATCH_OFF_W   = 32;
  localparam int PATTERN_BYTES = 16;
  localparam int ALIGN_W       = 13;
  localparam int PHASE_W       = 12;
  localparam int ALIGN_MAX     = 4096;
  localparam int PLEN_W        = 5;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [MATCH_OFF_W-1:0] match_off_t;

  localparam cfg_index_t REG_PATTERN_LOW  = 3'd0;
  localparam cfg_index_t REG_PATTERN_HIGH = 3'd1;
  localparam cfg_index_t REG_CARE_MASK    = 3'd2;
  localparam cfg_index_t REG_PATTERN_LEN  = 3'd3;
  localparam cfg_index_t REG_ALIGNMENT    = 3'd4;
  localparam cfg_index_t REG_FIND_ALL     = 3'd5;
  localparam cfg_index_t REG_REGION_BASE  = 3'd6;

endpackage

`default_nettype wire

// File: sv/wildcard_byte_pattern_scanner_core.sv
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner core
// Takes one region byte per cycle unless stalled and reports an aligned match
// of a pattern of up to 16 bytes with per-byte wildcards; every start offset
// is tried, so overlapping matches are found when find_all is set, else only
// the first in a region. The byte window, alignment marks and offset counter
// advance as an item is accepted into the compare stage registers, where all
// window positions are compared in parallel and a hit goes into the output
// register. Input is stalled only while a matching item waits behind an output
// register that is full and stalled. Configuration writes are always ready and
// must be made while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "wildcard_byte_pattern_scanner_core_macros.svh"

module wildcard_byte_pattern_scanner_core #(
  parameter int PATTERN_MAX = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  wbps_pkg::cfg_index_t cfg_index,
  input  wbps_pkg::cfg_data_t  cfg_data,
  // byte stream
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  logic [7:0]           data_byte,
  input  logic                 last_in_region,
  // match reports
  output logic                 match_valid,
  input  logic                 match_stall,
  output wbps_pkg::match_off_t match_offset,
  output wbps_pkg::addr_t      match_address
);
  import wbps_pkg::*;

  // only the pattern register's bytes can ever be compared
  localparam int WIN    = (PATTERN_MAX < PATTERN_BYTES) ? PATTERN_MAX : PATTERN_BYTES;
  localparam int IDX_W  = $clog2(WIN);
  localparam int SEEN_W = $clog2(WIN + 1);

  // configuration registers
  logic [63:0]          pattern_bytes_low;
  logic [63:0]          pattern_bytes_high;
  logic [15:0]          care_mask;
  logic [PLEN_W-1:0]    pattern_length;
  logic [ALIGN_W-1:0]   alignment;
  logic                 find_all;
  addr_t                region_base;

  // scan state
  logic [7:0]             win [WIN];
  logic [WIN-1:0]         marks;
  logic [SEEN_W-1:0]      bytes_seen;
  logic [OFFSET_BITS-1:0] position;
  logic [PHASE_W-1:0]     alignment_phase;
  logic                   already_found;

  // item in the compare stage
  logic                   s1_valid;
  logic                   s1_last;
  logic [SEEN_W-1:0]      s1_seen;
  logic [OFFSET_BITS-1:0] s1_start;

  logic [PLEN_W-1:0]      eff_len;
  logic [PLEN_W-1:0]      len_m1;
  logic [ALIGN_W-1:0]     eff_align;
  logic [ALIGN_W-1:0]     phase_inc;
  logic [PHASE_W-1:0]     phase_next;
  logic [SEEN_W-1:0]      bytes_seen_next;
  logic [127:0]           pattern_all;
  logic [PLEN_W-1:0]      tap [WIN];
  logic [WIN-1:0]         care_ok;
  logic                   hit;
  logic                   adv;
  logic                   accept;
  addr_t                  start_ext;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes_low  <= '0;
      pattern_bytes_high <= '0;
      care_mask          <= '0;
      pattern_length     <= '0;
      alignment          <= ALIGN_W'(1);
      find_all           <= 1'b0;
      region_base        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_LOW:  pattern_bytes_low  <= cfg_data;
        REG_PATTERN_HIGH: pattern_bytes_high <= cfg_data;
        REG_CARE_MASK:    care_mask          <= cfg_data[15:0];
        REG_PATTERN_LEN:  pattern_length     <= cfg_data[PLEN_W-1:0];
        REG_ALIGNMENT:    alignment          <= cfg_data[ALIGN_W-1:0];
        REG_FIND_ALL:     find_all           <= cfg_data[0];
        REG_REGION_BASE:  region_base        <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp length and alignment
  assign eff_len   = (pattern_length > PLEN_W'(WIN)) ? PLEN_W'(WIN) : pattern_length;
  assign len_m1    = eff_len - PLEN_W'(1);
  assign eff_align = (alignment == '0) ? ALIGN_W'(1) :
                     (alignment > ALIGN_W'(ALIGN_MAX)) ? ALIGN_W'(ALIGN_MAX) : alignment;

  // phase wraps as soon as it reaches or passes the alignment less one
  assign phase_inc  = {1'b0, alignment_phase} + ALIGN_W'(1);
  assign phase_next = (phase_inc >= eff_align) ? '0 : phase_inc[PHASE_W-1:0];

  assign bytes_seen_next = (bytes_seen < SEEN_W'(WIN)) ? bytes_seen + SEEN_W'(1) : bytes_seen;

  // compare stage
  assign pattern_all = {pattern_bytes_high, pattern_bytes_low};

  always_comb begin
    care_ok = '1;
    for (int i = 0; i < WIN; i++) begin
      tap[i] = len_m1 - PLEN_W'(i);
      if ((PLEN_W'(i) < eff_len) && care_mask[i] &&
          (win[tap[i][IDX_W-1:0]] != pattern_all[8*i +: 8])) begin
        care_ok[i] = 1'b0;
      end
    end
  end

  assign hit = s1_valid && (eff_len != '0) && (PLEN_W'(s1_seen) >= eff_len) &&
               marks[len_m1[IDX_W-1:0]] && (find_all || !already_found) && (&care_ok);

  // item leaves the compare stage unless its hit has nowhere to go
  assign adv        = s1_valid && (!hit || !match_valid || !match_stall);
  assign byte_stall = s1_valid && !adv;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      win[0]   <= data_byte;
      for (int i = 1; i < WIN; i++) begin
        win[i] <= win[i-1];
      end
      marks    <= {marks[WIN-2:0], (alignment_phase == '0)};
      s1_last  <= last_in_region;
      s1_seen  <= bytes_seen_next;
      s1_start <= position - OFFSET_BITS'(len_m1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen      <= '0;
      position        <= '0;
      alignment_phase <= '0;
      s1_valid        <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        if (last_in_region) begin
          bytes_seen      <= '0;
          position        <= '0;
          alignment_phase <= '0;
        end else begin
          bytes_seen      <= bytes_seen_next;
          position        <= position + OFFSET_BITS'(1);
          alignment_phase <= phase_next;
        end
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      already_found <= 1'b0;
    end else if (adv) begin
      already_found <= s1_last ? 1'b0 : (already_found | hit);
    end
  end

  // output register
  assign start_ext = ADDR_W'(s1_start);

  always_ff @(posedge clk) begin
    if (rst) begin
      match_valid <= 1'b0;
    end else if (adv && hit) begin
      match_valid <= 1'b1;
    end else if (!match_stall) begin
      match_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && hit) begin
      match_offset  <= start_ext[MATCH_OFF_W-1:0];
      match_address <= region_base + start_ext;
    end
  end

  `WBPS_ASSERT_NOW(a_stall_needs_pending_hit, clk, rst, byte_stall, hit && match_valid && match_stall, "input stalled without a blocked match")
  `WBPS_ASSERT_NEXT(a_first_mode_marks_found, clk, rst, adv && hit && !s1_last, already_found, "reported match not recorded for region")
  `WBPS_ASSERT_NEXT(a_region_end_clears, clk, rst, adv && s1_last, !already_found, "found flag survived region end")

endmodule

`default_nettype wire
